FILE: rtl/core/rbdas_pkg.sv
package rbdas_pkg;

  // field widths
  localparam int unsigned OPERAND_W = 30;
  localparam int unsigned RESULT_W  = 31;
  localparam int unsigned DIGIT_W   = 4;

  // radix register
  localparam logic [DIGIT_W-1:0] RADIX_RESET = 4'd10;
  localparam logic [DIGIT_W-1:0] RADIX_MIN   = 4'd2;
  localparam logic [DIGIT_W-1:0] RADIX_MAX   = 4'd10;

  // reciprocal of ten: q = (x * RECIP_TEN) >> RECIP_SHIFT, exact for x < 2^32
  localparam int unsigned RECIP_W     = 32;
  localparam int unsigned PROD_W      = OPERAND_W + RECIP_W;
  localparam int unsigned RECIP_SHIFT = 35;
  localparam logic [RECIP_W-1:0] RECIP_TEN = 32'hCCCC_CCCD;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_A,
    ST_MUL_B,
    ST_DIGIT,
    ST_ACCUM,
    ST_FINISH
  } state_t;

endpackage

FILE: rtl/core/radix_b_digit_add_subtract.sv
// Channel   Ports                                              Handshake
// input     in_kind, in_first_operand, in_second_operand       start & !busy
// result    out_result_value, out_underflow                     out_strobe, one cycle
// config    cfg_radix                                           cfg_valid & cfg_ready
//
// Each digit position steps through MUL_A, MUL_B, DIGIT and ACCUM, as the
// single shared divide-by-ten multiplier serves both operands in turn,
// then FINISH. out_strobe follows in the next cycle.
// Reset (synchronous, rst_n low) returns to idle with radix 10.
// The receiver cannot stall; a result is shown for exactly one cycle.
module radix_b_digit_add_subtract #(
  parameter int unsigned DIGIT_COUNT = 9
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start,
  output logic                                  busy,
  input  logic                                  in_kind,
  input  logic [rbdas_pkg::OPERAND_W-1:0]       in_first_operand,
  input  logic [rbdas_pkg::OPERAND_W-1:0]       in_second_operand,
  output logic                                  out_strobe,
  output logic [rbdas_pkg::RESULT_W-1:0]        out_result_value,
  output logic                                  out_underflow,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [rbdas_pkg::DIGIT_W-1:0]         cfg_radix
);

  localparam int unsigned CNT_W = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;
  localparam int unsigned DW    = rbdas_pkg::DIGIT_W;
  localparam int unsigned OW    = rbdas_pkg::OPERAND_W;
  localparam int unsigned RW    = rbdas_pkg::RESULT_W;

  rbdas_pkg::state_t state_r, state_nxt;

  logic [DW-1:0]    radix_r, radix_nxt;
  logic [DW-1:0]    r_r, r_nxt;
  logic             sub_r, sub_nxt;
  logic [OW-1:0]    a_r, a_nxt;
  logic [OW-1:0]    b_r, b_nxt;
  logic [DW-1:0]    da_r, da_nxt;
  logic [DW-1:0]    digit_r, digit_nxt;
  logic             link_r, link_nxt;
  logic [RW-1:0]    acc_r, acc_nxt;
  logic [RW-1:0]    place_r, place_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             strobe_r, strobe_nxt;
  logic [RW-1:0]    res_r, res_nxt;
  logic             uflow_r, uflow_nxt;

  logic             accept;
  logic             last_digit;
  logic             div_load;
  logic [OW-1:0]    div_opnd;
  logic [OW-1:0]    div_quot;
  logic [DW-1:0]    div_rem;
  logic [DW-1:0]    rem_clamped;
  logic [DW:0]      sum_w;
  logic [DW:0]      need_w;
  logic [DW-1:0]    db_w;

  // shared divide-by-ten unit
  rbdas_div10 u_div10 (
    .clk     (clk),
    .load    (div_load),
    .operand (div_opnd),
    .quot    (div_quot),
    .rem     (div_rem)
  );

  assign accept     = start && (state_r == rbdas_pkg::ST_IDLE);
  assign last_digit = (cnt_r == CNT_W'(DIGIT_COUNT - 1));

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      rbdas_pkg::ST_IDLE:   if (start) state_nxt = rbdas_pkg::ST_MUL_A;
      rbdas_pkg::ST_MUL_A:  state_nxt = rbdas_pkg::ST_MUL_B;
      rbdas_pkg::ST_MUL_B:  state_nxt = rbdas_pkg::ST_DIGIT;
      rbdas_pkg::ST_DIGIT:  state_nxt = rbdas_pkg::ST_ACCUM;
      rbdas_pkg::ST_ACCUM: begin
        state_nxt = last_digit ? rbdas_pkg::ST_FINISH : rbdas_pkg::ST_MUL_A;
      end
      rbdas_pkg::ST_FINISH: state_nxt = rbdas_pkg::ST_IDLE;
      default:              state_nxt = rbdas_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    busy      = 1'b1;
    div_load  = 1'b0;
    div_opnd  = a_r;
    case (state_r)
      rbdas_pkg::ST_IDLE:   busy = 1'b0;
      rbdas_pkg::ST_MUL_A:  div_load = 1'b1;
      rbdas_pkg::ST_MUL_B: begin
        div_load = 1'b1;
        div_opnd = b_r;
      end
      default: ;
    endcase
  end

  assign cfg_ready = !busy;

  // clamp the digit leaving the divider to radix-1
  assign rem_clamped = (div_rem >= r_r) ? (r_r - 4'd1) : div_rem;
  assign db_w        = rem_clamped;
  assign sum_w       = {1'b0, da_r} + {1'b0, db_w} + {{DW{1'b0}}, link_r};
  assign need_w      = {1'b0, db_w} + {{DW{1'b0}}, link_r};

  // datapath
  always_comb begin
    radix_nxt  = radix_r;
    r_nxt      = r_r;
    sub_nxt    = sub_r;
    a_nxt      = a_r;
    b_nxt      = b_r;
    da_nxt     = da_r;
    digit_nxt  = digit_r;
    link_nxt   = link_r;
    acc_nxt    = acc_r;
    place_nxt  = place_r;
    cnt_nxt    = cnt_r;
    strobe_nxt = 1'b0;
    res_nxt    = res_r;
    uflow_nxt  = uflow_r;

    if (cfg_valid && cfg_ready) radix_nxt = cfg_radix;

    case (state_r)
      rbdas_pkg::ST_IDLE: begin
        if (accept) begin
          // latch the word and the clamped radix
          if (radix_r < rbdas_pkg::RADIX_MIN)      r_nxt = rbdas_pkg::RADIX_MIN;
          else if (radix_r > rbdas_pkg::RADIX_MAX) r_nxt = rbdas_pkg::RADIX_MAX;
          else                                     r_nxt = radix_r;
          sub_nxt   = in_kind;
          a_nxt     = in_first_operand;
          b_nxt     = in_second_operand;
          link_nxt  = 1'b0;
          acc_nxt   = '0;
          place_nxt = RW'(1);
          cnt_nxt   = '0;
        end
      end
      rbdas_pkg::ST_MUL_B: begin
        // first operand digit out, shift the operand down
        a_nxt  = div_quot;
        da_nxt = rem_clamped;
      end
      rbdas_pkg::ST_DIGIT: begin
        b_nxt = div_quot;
        if (sub_r) begin
          if ({1'b0, da_r} >= need_w) begin
            digit_nxt = DW'({1'b0, da_r} - need_w);
            link_nxt  = 1'b0;
          end else begin
            digit_nxt = DW'({1'b0, da_r} + {1'b0, r_r} - need_w);
            link_nxt  = 1'b1;
          end
        end else begin
          if (sum_w >= {1'b0, r_r}) begin
            digit_nxt = DW'(sum_w - {1'b0, r_r});
            link_nxt  = 1'b1;
          end else begin
            digit_nxt = DW'(sum_w);
            link_nxt  = 1'b0;
          end
        end
      end
      rbdas_pkg::ST_ACCUM: begin
        // add digit at its decimal place, advance the place
        acc_nxt   = acc_r + RW'(RW'(digit_r) * place_r);
        place_nxt = RW'({place_r, 3'b000}) + RW'({place_r, 1'b0});
        if (!last_digit) cnt_nxt = cnt_r + CNT_W'(1);
      end
      rbdas_pkg::ST_FINISH: begin
        // leading carry digit for addition, flag for final borrow
        res_nxt    = (!sub_r && link_r) ? (acc_r + place_r) : acc_r;
        uflow_nxt  = sub_r && link_r;
        strobe_nxt = 1'b1;
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= rbdas_pkg::ST_IDLE;
      radix_r  <= rbdas_pkg::RADIX_RESET;
      strobe_r <= 1'b0;
      cnt_r    <= '0;
    end else begin
      state_r  <= state_nxt;
      radix_r  <= radix_nxt;
      strobe_r <= strobe_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    r_r     <= r_nxt;
    sub_r   <= sub_nxt;
    a_r     <= a_nxt;
    b_r     <= b_nxt;
    da_r    <= da_nxt;
    digit_r <= digit_nxt;
    link_r  <= link_nxt;
    acc_r   <= acc_nxt;
    place_r <= place_nxt;
    res_r   <= res_nxt;
    uflow_r <= uflow_nxt;
  end

  assign out_strobe       = strobe_r;
  assign out_result_value = res_r;
  assign out_underflow    = uflow_r;

endmodule

FILE: rtl/core/rbdas_div10.sv
// Divide-by-ten unit: reciprocal product and operand registered on load;
// quotient and remainder taken from them in the cycle after load.
module rbdas_div10 (
  input  logic                                 clk,
  input  logic                                 load,
  input  logic [rbdas_pkg::OPERAND_W-1:0]      operand,
  output logic [rbdas_pkg::OPERAND_W-1:0]      quot,
  output logic [rbdas_pkg::DIGIT_W-1:0]        rem
);

  logic [rbdas_pkg::PROD_W-1:0]    prod_r;
  logic [rbdas_pkg::OPERAND_W-1:0] opnd_r;
  logic [rbdas_pkg::DIGIT_W-1:0]   q_ten_lo;

  // capture product and operand
  always_ff @(posedge clk) begin
    if (load) begin
      prod_r <= rbdas_pkg::PROD_W'(operand) * rbdas_pkg::PROD_W'(rbdas_pkg::RECIP_TEN);
      opnd_r <= operand;
    end
  end

  // quotient is the top of the product; remainder needs only low bits
  assign quot     = rbdas_pkg::OPERAND_W'(prod_r >> rbdas_pkg::RECIP_SHIFT);
  assign q_ten_lo = {quot[0], 3'b000} + {quot[2:0], 1'b0};
  assign rem      = opnd_r[rbdas_pkg::DIGIT_W-1:0] - q_ten_lo;

endmodule
